// ===== hw/rtl/vpw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpw_pkg
// Shared types and constants of the vertex position welder.
// ----------------------------------------------------------------------------
package vpw_pkg;

  localparam int MAX_UNIQUE = 1024;
  localparam int IDX_W      = $clog2(MAX_UNIQUE);
  localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);
  localparam int COORD_W    = 32;
  localparam int TOL_W      = 16;
  localparam int UIDX_W     = 10;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

  localparam int IN_TDATA_W  = 3 * COORD_W;
  localparam int OUT_TDATA_W = ((UIDX_W + 7) / 8) * 8;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pos_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    pos_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [UIDX_W-1:0] index;
    logic              added;
    logic              overflow;
  } weld_res_t;

endpackage : vpw_pkg
`default_nettype wire

// ===== hw/rtl/vpw_pos_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpw_pos_ram
// Unique position store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vpw_pos_ram (
  input  wire logic              clk,
  input  wire vpw_pkg::ram_req_t req,
  output vpw_pkg::pos_t          rdata
);
  import vpw_pkg::*;

  pos_t mem [MAX_UNIQUE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule : vpw_pos_ram
`default_nettype wire

// ===== hw/rtl/vpw_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpw_match
// Per-axis tolerance compare of one stored position against the probe.
// ----------------------------------------------------------------------------
module vpw_match (
  input  wire vpw_pkg::pos_t                stored,
  input  wire vpw_pkg::pos_t                probe,
  input  wire logic [vpw_pkg::TOL_W-1:0]    tol,
  output logic                              hit
);
  import vpw_pkg::*;

  function automatic logic axis_close(input logic signed [COORD_W-1:0] s,
                                      input logic signed [COORD_W-1:0] p,
                                      input logic [TOL_W-1:0]          t);
    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] lim;
    diff = $signed({s[COORD_W-1], s}) - $signed({p[COORD_W-1], p});
    lim  = $signed({{(COORD_W + 1 - TOL_W){1'b0}}, t});
    return (diff <= lim) && (diff >= -lim);
  endfunction

  // difference is formed at one extra bit so it never wraps
  assign hit = axis_close(stored.x, probe.x, tol) &&
               axis_close(stored.y, probe.y, tol) &&
               axis_close(stored.z, probe.z, tol);

endmodule : vpw_match
`default_nettype wire

// ===== hw/rtl/vpw_weld_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpw_weld_ctrl
// Search sequencer: streams stored entries out of the ram, compares each one,
// appends on a miss unless the table is full, and holds the result until the output stage takes it.
// ----------------------------------------------------------------------------
module vpw_weld_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire vpw_pkg::pos_t              in_pos,
  input  wire logic                       in_start,
  input  wire logic [vpw_pkg::TOL_W-1:0]  tol,
  output vpw_pkg::ram_req_t               ram_req,
  input  wire vpw_pkg::pos_t              ram_rdata,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output vpw_pkg::weld_res_t              res
);
  import vpw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_UNIQUE);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  pos_t             probe_r, probe_nxt;
  weld_res_t        res_r, res_nxt;
  logic             hit;

  vpw_match u_match (
    .stored (ram_rdata),
    .probe  (probe_r),
    .tol    (tol),
    .hit    (hit)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    probe_nxt     = probe_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_req       = '0;
    ram_req.waddr = cnt_r[IDX_W-1:0];
    ram_req.wdata = probe_r;
    ram_req.raddr = iss_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          probe_nxt  = in_pos;
          cnt_nxt    = in_start ? '0 : cnt_r;
          iss_nxt    = '0;
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // issue the next read while the previous entry is compared
        if (iss_r < cnt_r) begin
          ram_req.re = 1'b1;
          iss_nxt    = iss_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r[IDX_W-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end

        if (rd_vld_r && hit) begin
          res_nxt.index    = UIDX_W'(rd_idx_r);
          res_nxt.added    = 1'b0;
          res_nxt.overflow = 1'b0;
          state_nxt        = ST_DONE;
        end else if (iss_r >= cnt_r) begin
          if (cnt_r == CNT_FULL) begin
            res_nxt.index    = '0;
            res_nxt.added    = 1'b0;
            res_nxt.overflow = 1'b1;
          end else begin
            ram_req.we       = 1'b1;
            res_nxt.index    = UIDX_W'(cnt_r[IDX_W-1:0]);
            res_nxt.added    = 1'b1;
            res_nxt.overflow = 1'b0;
            cnt_nxt          = cnt_r + CNT_W'(1);
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      iss_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      iss_r    <= iss_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    probe_r  <= probe_nxt;
    res_r    <= res_nxt;
  end

  assign res = res_r;

endmodule : vpw_weld_ctrl
`default_nettype wire

// ===== hw/rtl/vertex_position_welder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_position_welder
// Welds Q15.16 vertex positions against a table of unique positions.
//
//   channel  dir  handshake                  payload
//   in       in   in_tvalid / in_tready      in_tdata  x, y, z; in_tuser start_mesh
//   out      out  out_tvalid / out_tready    out_tdata unique_index; out_tuser flags
//   cfg      in   cfg_wr_en                  cfg_wr_data match_tolerance
//
// an item with N stored entries is searched by one ram read per entry; a hit
// on entry i ends the search there, and a miss against a full table overflows
// one transaction is searched at a time
// the next is taken in the cycle after its result has moved to the output
// register, which may still be waiting on out_tready
// reset empties the table and restores the tolerance to 7; no clearing pass
// ----------------------------------------------------------------------------
module vertex_position_welder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] x_coord, [63:32] y_coord, [95:64] z_coord
  input  wire logic [vpw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] start_mesh
  input  wire logic [0:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [9:0] unique_index, [15:10] zero
  output logic [vpw_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // [0] was_added, [1] table_overflow
  output logic [1:0]                             out_tuser,
  input  wire logic                              cfg_wr_en,
  input  wire logic [vpw_pkg::TOL_W-1:0]         cfg_wr_data
);
  import vpw_pkg::*;

  logic [TOL_W-1:0] tol_r;
  pos_t             in_pos;
  ram_req_t         ram_req;
  pos_t             ram_rdata;
  logic             res_valid;
  logic             res_ready;
  weld_res_t        res;
  logic             out_valid_r, out_valid_nxt;
  weld_res_t        out_res_r;

  assign in_pos.x = in_tdata[COORD_W-1:0];
  assign in_pos.y = in_tdata[2*COORD_W-1:COORD_W];
  assign in_pos.z = in_tdata[3*COORD_W-1:2*COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  vpw_pos_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  vpw_weld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pos    (in_pos),
    .in_start  (in_tuser[0]),
    .tol       (tol_r),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees the search side from the downstream stall
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = (out_valid_r && !out_tready) || res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r.index);
  assign out_tuser  = {out_res_r.overflow, out_res_r.added};

endmodule : vertex_position_welder
`default_nettype wire

// ===== hw/rtl/vpw_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpw_checker
// Port-level checks of the vertex position welder, bound to the top level.
// ----------------------------------------------------------------------------
module vpw_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [vpw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic [1:0]                        out_tuser
);
  import vpw_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an entry is either appended or the table overflowed, never both
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("was_added and table_overflow both set");

  a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[UIDX_W-1:0] == '0)
    else $error("overflow result with nonzero index");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:UIDX_W] == '0)
    else $error("tdata padding not zero");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule : vpw_checker

bind vertex_position_welder vpw_checker u_vpw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
